// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SRRW_ASSERT_IMPL(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("srrw: same-cycle check failed");

// Next-cycle implication
`define SRRW_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("srrw: next-cycle check failed");

`endif

// ===== hw/rtl/srrw_pkg.sv =====
// ----------------------------------------------------------------------------
// srrw_pkg
// Types and constants shared by the selective-repeat receive window files.
// ----------------------------------------------------------------------------
package srrw_pkg;

	// Received-map memory word geometry
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_NEW     = 2'd0,
		STAT_DUP     = 2'd1,
		STAT_OUTSIDE = 2'd2,
		STAT_FOREIGN = 2'd3
	} status_t;

	// Control sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIN,
		ST_CLASS,
		ST_MARK,
		ST_SRD,
		ST_SCHK,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage

// ===== hw/rtl/srrw_ram.sv =====
// ----------------------------------------------------------------------------
// srrw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module srrw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             ren,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/selective_repeat_receive_window.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Flow: a foreign segment goes from the window step straight to the result;
//   an out-of-window one is classified and finished; a duplicate or out-of-order
//   one is also looked up in the map and, if new, marked; an in-order one also scans map words.
// Throughput: one segment at a time, the next taken in the cycle the result appears;
//   the scan reads one 32-bit map word at a time, over up to a full 1024-entry
//   window. A stalled result holds the input off.
// Reset: asynchronous, clears the pointers, counters and map word valid bits.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window
	import srrw_pkg::*;
#(
	parameter int WINDOW = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: total_segments
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// Input segments
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] seg_index
	input  logic        s_tuser,   // [0] from_server
	// Results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [15:0] next_expected, [31:16] progress,
	                               // [32] window_done, [48:33] window_base,
	                               // [49] all_done, [55:50] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int DEPTH = (WINDOW + WORD_W - 1) / WORD_W;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OFF_W = $clog2(DEPTH * WORD_W + 1);

	state_t state_q, state_d;

	logic [15:0]      total_q;
	logic [15:0]      base_q;
	logic [15:0]      expected_q;
	logic [15:0]      count_q;
	logic [DEPTH-1:0] wvalid_q;

	logic [15:0]      seg_q;
	logic             from_q;
	logic [OFF_W-1:0] win_q;
	logic [15:0]      end_q;
	logic [BIT_W-1:0] bit_q;
	logic [AW-1:0]    word_q;
	status_t          status_q;
	logic             done_q;

	logic             m_tvalid_q;
	logic [55:0]      m_tdata_q;
	logic [1:0]       m_tuser_q;

	// RAM port signals
	logic              ram_we;
	logic              ram_ren;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	// Datapath terms
	logic [15:0]       left_c;
	logic [15:0]       win_c;
	logic              outside_c;
	logic [15:0]       seg_off_c;
	logic [15:0]       exp_off_c;
	logic [WORD_W-1:0] word_c;
	logic              bit_set_c;
	logic [OFF_W-1:0]  word_base_c;
	logic [WORD_W-1:0] avail_c;
	logic [BIT_W-1:0]  zero_pos_c;
	logic              all_ones_c;
	logic [OFF_W-1:0]  scan_off_c;
	logic              scan_cont_c;
	logic              accept_c;
	logic              out_free_c;

	srrw_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (word_q),
		.wdata (ram_wdata),
		.ren   (ram_ren),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept_c   = s_tvalid && s_tready;
	assign out_free_c = !m_tvalid_q || m_tready;

	// Window length and segment classification
	always_comb begin
		left_c    = (total_q > base_q) ? (total_q - base_q) : 16'd0;
		win_c     = (left_c > 16'(WINDOW)) ? 16'(WINDOW) : left_c;
		outside_c = (seg_q < base_q) || (seg_q >= end_q);
		seg_off_c = seg_q - base_q;
		exp_off_c = expected_q - base_q;
	end

	// Map word as read, words never written since the last clear read as zero
	always_comb begin
		word_c    = wvalid_q[word_q] ? ram_rdata : '0;
		bit_set_c = word_c[bit_q];
		ram_wdata = word_c | (WORD_W'(1) << bit_q);
	end

	// In-order scan over one map word: first hole at or after bit_q
	always_comb begin
		logic [OFF_W-1:0] pos;
		word_base_c = OFF_W'({word_q, {BIT_W{1'b0}}});
		for (int j = 0; j < WORD_W; j++) begin
			pos = word_base_c + OFF_W'(j);
			if (pos >= win_q) begin
				avail_c[j] = 1'b0;
			end else begin
				avail_c[j] = word_c[j] || (BIT_W'(j) < bit_q);
			end
		end
		all_ones_c = &avail_c;
		zero_pos_c = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (!avail_c[j]) begin
				zero_pos_c = BIT_W'(j);
			end
		end
		if (all_ones_c) begin
			scan_off_c  = word_base_c + OFF_W'(WORD_W);
			scan_cont_c = scan_off_c < win_q;
		end else begin
			scan_off_c  = word_base_c + OFF_W'(zero_pos_c);
			scan_cont_c = 1'b0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept_c) state_d = ST_WIN;
			ST_WIN:   state_d = from_q ? ST_CLASS : ST_OUT;
			ST_CLASS: state_d = outside_c ? ST_FIN : ST_MARK;
			ST_MARK: begin
				if (!bit_set_c && (seg_q == expected_q)) state_d = ST_SRD;
				else state_d = ST_FIN;
			end
			ST_SRD:   state_d = ST_SCHK;
			ST_SCHK:  state_d = scan_cont_c ? ST_SRD : ST_FIN;
			ST_FIN:   state_d = ST_OUT;
			ST_OUT:   if (out_free_c) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		s_tready  = 1'b0;
		ram_ren   = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_CLASS: begin
				ram_ren   = !outside_c;
				ram_raddr = seg_off_c[BIT_W +: AW];
			end
			ST_MARK:  ram_we = !bit_set_c;
			ST_SRD: begin
				ram_ren   = 1'b1;
				ram_raddr = exp_off_c[BIT_W +: AW];
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= '0;
			base_q     <= '0;
			expected_q <= '0;
			count_q    <= '0;
			wvalid_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				total_q <= cfg_data;
			end
			if (state_q == ST_MARK && !bit_set_c) begin
				wvalid_q[word_q] <= 1'b1;
				count_q          <= count_q + 16'd1;
			end
			if (state_q == ST_SCHK) begin
				expected_q <= base_q + 16'(scan_off_c);
			end
			// Window completes: move base, restart pointer, clear the map
			if (state_q == ST_FIN && win_q != '0 && expected_q >= end_q) begin
				base_q     <= end_q;
				expected_q <= end_q;
				wvalid_q   <= '0;
			end
			if (state_q == ST_OUT && out_free_c) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Per-transaction working registers and result payload
	always_ff @(posedge clk) begin
		if (accept_c) begin
			seg_q  <= s_tdata;
			from_q <= s_tuser;
		end
		case (state_q)
			ST_WIN: begin
				win_q    <= OFF_W'(win_c);
				end_q    <= base_q + win_c;
				done_q   <= 1'b0;
				status_q <= STAT_FOREIGN;
			end
			ST_CLASS: begin
				status_q <= outside_c ? STAT_OUTSIDE : STAT_NEW;
				bit_q    <= seg_off_c[BIT_W-1:0];
				word_q   <= seg_off_c[BIT_W +: AW];
			end
			ST_MARK: begin
				if (bit_set_c) status_q <= STAT_DUP;
			end
			ST_SRD: begin
				bit_q  <= exp_off_c[BIT_W-1:0];
				word_q <= exp_off_c[BIT_W +: AW];
			end
			ST_FIN: begin
				done_q <= (win_q != '0) && (expected_q >= end_q);
			end
			ST_OUT: begin
				if (out_free_c) begin
					m_tdata_q <= {6'd0, (base_q >= total_q), base_q, done_q,
					              count_q, expected_q};
					m_tuser_q <= status_q;
				end
			end
			default: begin
				done_q <= done_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== hw/rtl/srrw_checker.sv =====
// ----------------------------------------------------------------------------
// srrw_checker
// Port-level checks on the result stream of the receive window.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srrw_checker
	import srrw_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A stalled result transaction holds
	`SRRW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// A completed window restarts the in-order pointer at the new base
	`SRRW_ASSERT_IMPL(a_done_restart, m_tvalid && m_tdata[32], m_tdata[15:0] == m_tdata[48:33])

	// A foreign segment never completes a window
	`SRRW_ASSERT_IMPL(a_foreign_quiet, m_tvalid && m_tuser == STAT_FOREIGN, !m_tdata[32])

	// The in-order pointer never falls below the window base
	`SRRW_ASSERT_IMPL(a_exp_ge_base, m_tvalid, m_tdata[15:0] >= m_tdata[48:33])

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (.*);
